// File: rtl/dtec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtec_pkg
// Shared types and constants for the date/time to seconds converter: the
// word carried down the pipeline and the cumulative day offset table.
// ----------------------------------------------------------------------------
package dtec_pkg;

    localparam int NUM_STAGES = 6;

    localparam logic [10:0] BLOCK_DAYS = 11'd1461;

    // blk = (days * BLOCK_RECIP) >> BLOCK_SHIFT is exact for days below 94519
    localparam logic [16:0] BLOCK_RECIP = 17'd91868;
    localparam int          BLOCK_SHIFT = 27;

    // q = (x * RECIP_60) >> 37 and q = (x * RECIP_24) >> 36, exact for 32-bit x
    localparam logic [31:0] RECIP_60 = 32'h8888_8889;
    localparam logic [31:0] RECIP_24 = 32'hAAAA_AAAB;

    localparam logic [0:0] REQ_PACK   = 1'b0;
    localparam logic [0:0] REQ_UNPACK = 1'b1;

    localparam logic [10:0] DAY_OFFSET [4][12] = '{
        '{11'd0,    11'd31,   11'd60,   11'd91,   11'd121,  11'd152,
          11'd182,  11'd213,  11'd244,  11'd274,  11'd305,  11'd335},
        '{11'd366,  11'd397,  11'd425,  11'd456,  11'd486,  11'd517,
          11'd547,  11'd578,  11'd609,  11'd639,  11'd670,  11'd700},
        '{11'd731,  11'd762,  11'd790,  11'd821,  11'd851,  11'd882,
          11'd912,  11'd943,  11'd974,  11'd1004, 11'd1035, 11'd1065},
        '{11'd1096, 11'd1127, 11'd1155, 11'd1186, 11'd1216, 11'd1247,
          11'd1277, 11'd1308, 11'd1339, 11'd1369, 11'd1400, 11'd1430}
    };

    // acc holds days/seconds when packing, else the running quotient and then
    // the day in block; sec, min and hour hold inputs, or results when unpacking
    typedef struct packed {
        logic        req;
        logic [31:0] acc;
        logic [5:0]  sec;
        logic [5:0]  min;
        logic [4:0]  hour;
        logic [4:0]  day;
        logic [3:0]  month;
        logic [7:0]  year;
        logic [1:0]  row;
    } dtec_word_t;

endpackage
`default_nettype wire

// File: rtl/date_time_epoch_converter.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// date_time_epoch_converter
// Converts between a broken-down date and time and seconds since
// 2000-01-01 00:00:00, in either direction as tuser selects.
// ----------------------------------------------------------------------------
// One word is accepted every cycle unless m_axis_tready stalls the output; each
// word passes through the six-register pipeline: three reciprocal multiply
// stages split off seconds, minutes and hours, then four-year blocks, the year
// within the block, and the month and day from the offset table. Packing runs
// the days*24+h, *60+m, *60+s chain through the same stages. Every year
// divisible by four is a leap year, so dates are right for 2000 through 2099.
// Day of month is not checked against month length.
// ----------------------------------------------------------------------------
module date_time_epoch_converter (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // epoch_in, sec_in, min_in, hour_in, day_in, month_in, year_in, zero pad
    input  wire  [71:0] s_axis_tdata,
    // req_type
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // epoch_out, sec_out, min_out, hour_out, day_out, month_out, year_out, zero pad
    output logic [71:0] m_axis_tdata
);
    import dtec_pkg::*;

    dtec_word_t stage_in    [NUM_STAGES];
    dtec_word_t stage_out   [NUM_STAGES];
    logic       stage_vin   [NUM_STAGES];
    logic       stage_vout  [NUM_STAGES];
    logic       stage_rin   [NUM_STAGES];
    logic       stage_rout  [NUM_STAGES];

    genvar k;
    generate
        for (k = 0; k < NUM_STAGES; k++) begin : g_stage
            dtec_pipe_reg u_reg (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (stage_vin[k]),
                .in_ready  (stage_rin[k]),
                .in_data   (stage_in[k]),
                .out_valid (stage_vout[k]),
                .out_ready (stage_rout[k]),
                .out_data  (stage_out[k])
            );
            if (k > 0) begin : g_link
                assign stage_vin[k]    = stage_vout[k-1];
                assign stage_rout[k-1] = stage_rin[k];
            end
        end
    endgenerate

    assign stage_vin[0]              = s_axis_tvalid;
    assign s_axis_tready             = stage_rin[0];
    assign m_axis_tvalid             = stage_vout[NUM_STAGES-1];
    assign stage_rout[NUM_STAGES-1]  = m_axis_tready;

    // stage 1: days from the date, or seconds split off
    logic [31:0] in_epoch;
    logic [3:0]  in_month;
    logic [6:0]  in_year;
    logic [4:0]  in_day;
    logic [3:0]  mon_idx;
    logic [31:0] days;
    logic [63:0] prod1;
    logic [31:0] quot1;
    logic [31:0] rem1;

    assign in_epoch = s_axis_tdata[31:0];
    assign in_day   = s_axis_tdata[53:49];
    assign in_month = s_axis_tdata[57:54];
    assign in_year  = s_axis_tdata[64:58];

    always_comb begin
        priority if (in_month == 4'd0) begin
            mon_idx = 4'd0;
        end else if (in_month > 4'd12) begin
            mon_idx = 4'd11;
        end else begin
            mon_idx = in_month - 4'd1;
        end
        days  = 32'(in_year[6:2]) * 32'(BLOCK_DAYS)
              + 32'(DAY_OFFSET[in_year[1:0]][mon_idx]) + 32'(in_day) - 32'd1;
        prod1 = 64'(in_epoch) * 64'(RECIP_60);
        quot1 = 32'(prod1 >> 37);
        rem1  = in_epoch - quot1 * 32'd60;

        stage_in[0]       = '0;
        stage_in[0].req   = s_axis_tuser[0];
        if (s_axis_tuser[0] == REQ_UNPACK) begin
            stage_in[0].acc = quot1;
            stage_in[0].sec = rem1[5:0];
        end else begin
            stage_in[0].acc  = days;
            stage_in[0].sec  = s_axis_tdata[37:32];
            stage_in[0].min  = s_axis_tdata[43:38];
            stage_in[0].hour = s_axis_tdata[48:44];
        end
    end

    // stage 2: times 24 plus hour, or minutes split off
    logic [63:0] prod2;
    logic [31:0] quot2;
    logic [31:0] rem2;

    always_comb begin
        prod2       = 64'(stage_out[0].acc) * 64'(RECIP_60);
        quot2       = 32'(prod2 >> 37);
        rem2        = stage_out[0].acc - quot2 * 32'd60;
        stage_in[1] = stage_out[0];
        if (stage_out[0].req == REQ_UNPACK) begin
            stage_in[1].acc = quot2;
            stage_in[1].min = rem2[5:0];
        end else begin
            stage_in[1].acc = stage_out[0].acc * 32'd24 + 32'(stage_out[0].hour);
        end
    end

    // stage 3: times 60 plus minute, or hours split off
    logic [63:0] prod3;
    logic [31:0] quot3;
    logic [31:0] rem3;

    always_comb begin
        prod3       = 64'(stage_out[1].acc) * 64'(RECIP_24);
        quot3       = 32'(prod3 >> 36);
        rem3        = stage_out[1].acc - quot3 * 32'd24;
        stage_in[2] = stage_out[1];
        if (stage_out[1].req == REQ_UNPACK) begin
            stage_in[2].acc  = quot3;
            stage_in[2].hour = rem3[4:0];
        end else begin
            stage_in[2].acc = stage_out[1].acc * 32'd60 + 32'(stage_out[1].min);
        end
    end

    // stage 4: times 60 plus second, or four-year blocks split off
    logic [33:0] prod4;
    logic [5:0]  blk;
    logic [16:0] rem4;

    always_comb begin
        prod4       = 34'(stage_out[2].acc[16:0]) * 34'(BLOCK_RECIP);
        blk         = prod4[BLOCK_SHIFT+5:BLOCK_SHIFT];
        rem4        = stage_out[2].acc[16:0] - 17'(blk) * 17'(BLOCK_DAYS);
        stage_in[3] = stage_out[2];
        if (stage_out[2].req == REQ_UNPACK) begin
            stage_in[3].acc  = 32'(rem4);
            stage_in[3].year = {blk, 2'b00};
        end else begin
            stage_in[3].acc = stage_out[2].acc * 32'd60 + 32'(stage_out[2].sec);
        end
    end

    // stage 5: year within the block
    logic [10:0] rem5;
    logic [1:0]  yr5;

    always_comb begin
        rem5 = stage_out[3].acc[10:0];
        priority if (rem5 >= DAY_OFFSET[3][0]) begin
            yr5 = 2'd3;
        end else if (rem5 >= DAY_OFFSET[2][0]) begin
            yr5 = 2'd2;
        end else if (rem5 >= DAY_OFFSET[1][0]) begin
            yr5 = 2'd1;
        end else begin
            yr5 = 2'd0;
        end
        stage_in[4] = stage_out[3];
        if (stage_out[3].req == REQ_UNPACK) begin
            stage_in[4].row  = yr5;
            stage_in[4].year = stage_out[3].year + 8'(yr5);
        end
    end

    // stage 6: month and day from the offset table
    logic [10:0] rem6;
    logic [3:0]  mo6;
    logic [10:0] day6;

    always_comb begin
        rem6 = stage_out[4].acc[10:0];
        mo6  = 4'd0;
        for (int m = 1; m < 12; m++) begin
            if (rem6 >= DAY_OFFSET[stage_out[4].row][4'(m)]) begin
                mo6 = 4'(m);
            end
        end
        day6        = rem6 - DAY_OFFSET[stage_out[4].row][mo6] + 11'd1;
        stage_in[5] = stage_out[4];
        if (stage_out[4].req == REQ_UNPACK) begin
            stage_in[5].day   = day6[4:0];
            stage_in[5].month = mo6 + 4'd1;
        end
    end

    // result word
    dtec_word_t res;

    always_comb begin
        res = stage_out[NUM_STAGES-1];
        if (res.req == REQ_UNPACK) begin
            m_axis_tdata = {6'd0, res.year, res.month, res.day, res.hour,
                            res.min, res.sec, 32'd0};
        end else begin
            m_axis_tdata = {40'd0, res.acc};
        end
    end

endmodule
`default_nettype wire

// File: rtl/dtec_pipe_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtec_pipe_reg
// One pipeline register with its valid bit; it takes a new word whenever it
// is empty or its word leaves in the same cycle.
// ----------------------------------------------------------------------------
module dtec_pipe_reg (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     in_valid,
    output logic                    in_ready,
    input  dtec_pkg::dtec_word_t    in_data,
    output logic                    out_valid,
    input  wire                     out_ready,
    output dtec_pkg::dtec_word_t    out_data
);
    import dtec_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    dtec_word_t data_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;
    assign out_valid  = valid_reg;
    assign out_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= in_data;
        end
    end

endmodule
`default_nettype wire
